/* hw/rtl/multi_channel_double_tap_detector_core_assert.svh */
// Assertion macros shared by the double-tap detector RTL.
// Depends on nothing; files that check their own logic include it.
`ifndef MULTI_CHANNEL_DOUBLE_TAP_DETECTOR_CORE_ASSERT_SVH
`define MULTI_CHANNEL_DOUBLE_TAP_DETECTOR_CORE_ASSERT_SVH

`ifndef SYNTH
// Clocked check that is switched off while reset is held.
`define MCDT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mcdt assertion failed");
// Clocked check that also holds during reset.
`define MCDT_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("mcdt assertion failed");
`else
`define MCDT_ASSERT(lbl, clk, rst_n, prop)
`define MCDT_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

/* hw/rtl/mcdt_pkg.sv */
// Package for the double-tap detector: widths, codes, reset values and types.
// Depends on nothing; every RTL file of the block imports it.
package mcdt_pkg;

  // Channel count and field widths.
  localparam int CHANNELS  = 16;
  localparam int MASK_W    = 16;
  localparam int TIME_W    = 32;
  localparam int WIN_W     = 16;
  localparam int CNT_W     = 2;
  localparam int PACK_W    = 32;
  localparam int CFG_IDX_W = 8;

  // Register reset values and the count ceiling.
  localparam logic [WIN_W-1:0] TAP_WINDOW_RST    = 16'd300;
  localparam logic [WIN_W-1:0] DOUBLE_WINDOW_RST = 16'd200;
  localparam logic [CNT_W-1:0] COUNT_MAX         = 2'd2;
  localparam logic [CNT_W-1:0] COUNT_ONE         = 2'd1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TAP_WINDOW    = 8'd0,
    REG_DOUBLE_WINDOW = 8'd1
  } cfg_reg_t;

  // Detector phases, one-hot.
  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_TAP     = 4'b0010,
    PH_DOUBLE  = 4'b0100,
    PH_EXPIRED = 4'b1000
  } phase_t;

  // Window lengths handed from the register file to the engine.
  typedef struct packed {
    logic [WIN_W-1:0] tap_win;
    logic [WIN_W-1:0] dbl_win;
  } win_cfg_t;

endpackage

/* hw/rtl/mcdt_cfg.sv */
// Configuration registers of the double-tap detector (tap and double-tap windows).
// Depends on mcdt_pkg.
module mcdt_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mcdt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mcdt_pkg::WIN_W-1:0]    cfg_data,
  output mcdt_pkg::win_cfg_t            win_cfg
);
  import mcdt_pkg::*;

  logic [WIN_W-1:0] tap_win_r;
  logic [WIN_W-1:0] dbl_win_r;

  // Writes are always taken.
  assign cfg_ready = 1'b1;

  // Register write; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_win_r <= TAP_WINDOW_RST;
      dbl_win_r <= DOUBLE_WINDOW_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TAP_WINDOW:    tap_win_r <= cfg_data;
        REG_DOUBLE_WINDOW: dbl_win_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign win_cfg.tap_win = tap_win_r;
  assign win_cfg.dbl_win = dbl_win_r;

endmodule

/* hw/rtl/mcdt_engine.sv */
// Tap counting engine: phase, per-channel counts and window start times.
// Depends on mcdt_pkg and the assertion macro header.
`include "multi_channel_double_tap_detector_core_assert.svh"

module mcdt_engine (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic [mcdt_pkg::MASK_W-1:0] tap_mask,
  input  logic [mcdt_pkg::TIME_W-1:0] time_ms,
  input  mcdt_pkg::win_cfg_t          win_cfg,
  output logic                        res_vld,
  output logic [mcdt_pkg::PACK_W-1:0] res_packed
);
  import mcdt_pkg::*;

  phase_t            phase_r, phase_nxt;
  logic [CNT_W-1:0]  cnt_r   [CHANNELS];
  logic [CNT_W-1:0]  cnt_nxt [CHANNELS];
  logic [TIME_W-1:0] first_r, first_nxt;
  logic [TIME_W-1:0] dbl_r, dbl_nxt;
  logic [TIME_W-1:0] tap_elapsed;
  logic [TIME_W-1:0] dbl_elapsed;
  logic              tap_expired;
  logic              dbl_expired;
  logic              any_tap;
  logic              twice;
  logic              emit;
  logic [CNT_W:0]    sum [CHANNELS];

  // Elapsed times wrap modulo 2^32; a window closes once elapsed reaches its length.
  assign tap_elapsed = time_ms - first_r;
  assign dbl_elapsed = time_ms - dbl_r;
  assign tap_expired = tap_elapsed >= {{(TIME_W-WIN_W){1'b0}}, win_cfg.tap_win};
  assign dbl_expired = dbl_elapsed >= {{(TIME_W-WIN_W){1'b0}}, win_cfg.dbl_win};
  assign any_tap     = |tap_mask[CHANNELS-1:0];

  // Per-channel saturating sums used in the tap and double-tap windows.
  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      sum[i] = {1'b0, cnt_r[i]} + {{CNT_W{1'b0}}, tap_mask[i]};
      if (sum[i] > {1'b0, COUNT_MAX}) begin
        sum[i] = {1'b0, COUNT_MAX};
      end
    end
  end

  // Phase and count update for one beat.
  always_comb begin
    phase_nxt = phase_r;
    first_nxt = first_r;
    dbl_nxt   = dbl_r;
    cnt_nxt   = cnt_r;
    twice     = 1'b0;
    emit      = 1'b0;
    case (phase_r)
      PH_IDLE: begin
        if (any_tap) begin
          first_nxt = time_ms;
          for (int i = 0; i < CHANNELS; i++) begin
            cnt_nxt[i] = {{(CNT_W-1){1'b0}}, tap_mask[i]};
          end
          phase_nxt = PH_TAP;
        end
      end
      PH_TAP: begin
        if (tap_expired) begin
          phase_nxt = PH_EXPIRED;
        end else begin
          for (int i = 0; i < CHANNELS; i++) begin
            cnt_nxt[i] = sum[i][CNT_W-1:0];
            if (sum[i][CNT_W-1:0] == COUNT_MAX) begin
              twice = 1'b1;
            end
          end
          if (twice) begin
            dbl_nxt   = time_ms;
            phase_nxt = PH_DOUBLE;
          end
        end
      end
      PH_DOUBLE: begin
        if (dbl_expired) begin
          // Single taps are promoted when the double-tap window closes.
          for (int i = 0; i < CHANNELS; i++) begin
            if (cnt_r[i] == COUNT_ONE) begin
              cnt_nxt[i] = COUNT_MAX;
            end
          end
          phase_nxt = PH_EXPIRED;
        end else begin
          for (int i = 0; i < CHANNELS; i++) begin
            if (cnt_r[i] < COUNT_MAX) begin
              cnt_nxt[i] = sum[i][CNT_W-1:0];
            end
          end
        end
      end
      PH_EXPIRED: begin
        emit      = 1'b1;
        phase_nxt = PH_IDLE;
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // State registers advance only on a processed beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      first_r <= '0;
      dbl_r   <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (step) begin
      phase_r <= phase_nxt;
      first_r <= first_nxt;
      dbl_r   <= dbl_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Pack the counts; positions above the channel count stay zero.
  always_comb begin
    res_packed = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      res_packed[CNT_W*i +: CNT_W] = cnt_r[i];
    end
  end

  assign res_vld = step && emit;

  // A reported beat always returns the detector to idle.
  `MCDT_ASSERT(a_emit_to_idle, clk, rst_n, res_vld |=> phase_r == PH_IDLE)
  // Without a processed beat the phase and counts hold.
  `MCDT_ASSERT(a_hold_no_step, clk, rst_n, !step |=> $stable(phase_r) && $stable(res_packed))
  // The double-tap window only stays open or expires.
  `MCDT_ASSERT(a_double_exit, clk, rst_n,
    step && phase_r == PH_DOUBLE |=> phase_r == PH_DOUBLE || phase_r == PH_EXPIRED)

endmodule

/* hw/rtl/multi_channel_double_tap_detector_core.sv */
// Multi-channel double-tap detector, top level.
// Path: input register, then result register; a stalled full result register holds the input.
// Throughput: one item per cycle; the input register and the result register each take a
// beat while the other side stalls, so both sides move every cycle when free.
// Reset: rst_n is synchronous, active low; phase goes idle, counts and times clear,
// window registers load 300 ms and 200 ms.
module multi_channel_double_tap_detector_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [mcdt_pkg::MASK_W-1:0]    in_tap_mask,
  input  logic [mcdt_pkg::TIME_W-1:0]    in_time_ms,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [mcdt_pkg::PACK_W-1:0]    out_packed_counts,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mcdt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mcdt_pkg::WIN_W-1:0]     cfg_data
);
  import mcdt_pkg::*;

  `include "multi_channel_double_tap_detector_core_assert.svh"

  win_cfg_t          win_cfg;
  logic              in_vld_r, in_vld_nxt;
  logic [MASK_W-1:0] in_mask_r;
  logic [TIME_W-1:0] in_time_r;
  logic              out_vld_r, out_vld_nxt;
  logic [PACK_W-1:0] out_data_r;
  logic              adv;
  logic              in_acc;
  logic              res_vld;
  logic [PACK_W-1:0] res_packed;

  // Configuration registers.
  mcdt_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .win_cfg   (win_cfg)
  );

  // The held beat is processed when the result register is free or draining.
  assign adv      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  // Input register.
  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_acc) begin
      in_vld_nxt = 1'b1;
    end else if (adv) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_mask_r <= in_tap_mask;
      in_time_r <= in_time_ms;
    end
  end

  // Counting engine.
  mcdt_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (adv),
    .tap_mask   (in_mask_r),
    .time_ms    (in_time_r),
    .win_cfg    (win_cfg),
    .res_vld    (res_vld),
    .res_packed (res_packed)
  );

  // Result register.
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (res_vld) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld) begin
      out_data_r <= res_packed;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_packed_counts = out_data_r;

  // A new result only enters a free or draining result register.
  `MCDT_ASSERT(a_no_overwrite, clk, rst_n, res_vld |-> !out_vld_r || !out_stall)
  // Every engine result appears on the output in the next cycle.
  `MCDT_ASSERT(a_result_shown, clk, rst_n, res_vld |=> out_valid)
  // A held beat that cannot advance is kept.
  `MCDT_ASSERT(a_in_kept, clk, rst_n, in_vld_r && !adv |=> in_vld_r && $stable(in_time_r))

endmodule

/* sim/mcdt_tap_count_checker.sv */
// Checker for the double-tap detector: watches the tap, count and register channels,
// predicts every packed count report and compares it with what the block delivers.
// Depends on mcdt_pkg for widths, register indexes and phase codes.
module mcdt_tap_count_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [mcdt_pkg::MASK_W-1:0]    in_tap_mask,
  input  logic [mcdt_pkg::TIME_W-1:0]    in_time_ms,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [mcdt_pkg::PACK_W-1:0]    out_packed_counts,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [mcdt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mcdt_pkg::WIN_W-1:0]     cfg_data,
  output int unsigned                    fail_count,
  output int unsigned                    pending,
  output int unsigned                    reports_seen
);
  import mcdt_pkg::*;

  // Shadow of the detector state and its window registers.
  phase_t           det_phase;
  logic [CNT_W-1:0] chan_cnt [CHANNELS];
  logic [TIME_W-1:0] tap_start;
  logic [TIME_W-1:0] dbl_start;
  logic [WIN_W-1:0] tap_win_ms;
  logic [WIN_W-1:0] dbl_win_ms;

  // Count reports still owed by the block, oldest first.
  logic [PACK_W-1:0] expected_reports [$];
  int unsigned       n_err = 0;
  int unsigned       n_rep = 0;

  // Advance the shadow detector by one tap beat; queue a report when one is due.
  task automatic track_taps(input logic [MASK_W-1:0] mask, input logic [TIME_W-1:0] stamp);
    logic [TIME_W-1:0] elapsed;
    logic [CNT_W:0]    sum;
    logic [PACK_W-1:0] cnt_word;
    bit                hit_max;
    case (det_phase)
      PH_IDLE: begin
        if (mask != '0) begin
          tap_start = stamp;
          for (int i = 0; i < CHANNELS; i++) chan_cnt[i] = {1'b0, mask[i]};
          det_phase = PH_TAP;
        end
      end
      PH_TAP: begin
        elapsed = stamp - tap_start;
        if (elapsed >= {{(TIME_W-WIN_W){1'b0}}, tap_win_ms}) begin
          // The beat that sees the timeout does not count its taps.
          det_phase = PH_EXPIRED;
        end else begin
          hit_max = 1'b0;
          for (int i = 0; i < CHANNELS; i++) begin
            sum = {1'b0, chan_cnt[i]} + {{CNT_W{1'b0}}, mask[i]};
            if (sum > {1'b0, COUNT_MAX}) sum = {1'b0, COUNT_MAX};
            chan_cnt[i] = sum[CNT_W-1:0];
            if (chan_cnt[i] == COUNT_MAX) hit_max = 1'b1;
          end
          if (hit_max) begin
            dbl_start = stamp;
            det_phase = PH_DOUBLE;
          end
        end
      end
      PH_DOUBLE: begin
        elapsed = stamp - dbl_start;
        if (elapsed >= {{(TIME_W-WIN_W){1'b0}}, dbl_win_ms}) begin
          // Channels that tapped once are promoted when the window closes.
          for (int i = 0; i < CHANNELS; i++)
            if (chan_cnt[i] == COUNT_ONE) chan_cnt[i] = COUNT_MAX;
          det_phase = PH_EXPIRED;
        end else begin
          for (int i = 0; i < CHANNELS; i++)
            if (chan_cnt[i] < COUNT_MAX) chan_cnt[i] = chan_cnt[i] + {1'b0, mask[i]};
        end
      end
      default: begin
        // Expired: this beat's mask and time are ignored and the counts go out.
        cnt_word = '0;
        for (int i = 0; i < CHANNELS; i++) cnt_word[2*i +: 2] = chan_cnt[i];
        expected_reports.push_back(cnt_word);
        det_phase = PH_IDLE;
      end
    endcase
  endtask

  // Compare delivered reports first, then apply register writes and new tap beats.
  always @(posedge clk) begin
    logic [PACK_W-1:0] want;
    if (!rst_n) begin
      det_phase  = PH_IDLE;
      for (int i = 0; i < CHANNELS; i++) chan_cnt[i] = '0;
      tap_start  = '0;
      dbl_start  = '0;
      tap_win_ms = TAP_WINDOW_RST;
      dbl_win_ms = DOUBLE_WINDOW_RST;
      expected_reports.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          if (n_err < 10)
            $display("[%0t] unexpected count report 0x%08h", $realtime, out_packed_counts);
          n_err++;
        end else begin
          want = expected_reports.pop_front();
          n_rep++;
          if (out_packed_counts !== want) begin
            if (n_err < 10)
              $display("[%0t] packed_counts mismatch: expected 0x%08h, got 0x%08h",
                       $realtime, want, out_packed_counts);
            n_err++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TAP_WINDOW:    tap_win_ms = cfg_data;
          REG_DOUBLE_WINDOW: dbl_win_ms = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) track_taps(in_tap_mask, in_time_ms);
    end
    fail_count   <= n_err;
    pending      <= expected_reports.size();
    reports_seen <= n_rep;
  end

endmodule

/* sim/multi_channel_double_tap_detector_core_tb.sv */
// Testbench top for the double-tap detector: clock, reset, tap and register stimulus,
// a stalling report receiver, a watchdog and the verdict.
// Depends on mcdt_pkg, the detector RTL and the mcdt_tap_count_checker module.
module multi_channel_double_tap_detector_core_tb;
  import mcdt_pkg::*;

  localparam int unsigned IDLE_LIMIT = 5000;
  localparam int unsigned RX_HOLD    = 80;
  localparam int unsigned PHASES     = 7;
  localparam int unsigned PHASE_BEATS = 93;

  // Indexes past the register file, written to show they are ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 8'hFF;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [MASK_W-1:0]    in_tap_mask = '0;
  logic [TIME_W-1:0]    in_time_ms = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [PACK_W-1:0]    out_packed_counts;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WIN_W-1:0]     cfg_data = '0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned reports_seen;
  int unsigned beats_sent = 0;
  int unsigned reg_writes = 0;
  int unsigned idle_cycles = 0;
  bit          traffic_on = 1'b0;
  logic [WIN_W-1:0] tw_ms = TAP_WINDOW_RST;
  logic [WIN_W-1:0] dw_ms = DOUBLE_WINDOW_RST;

  always #1 clk = ~clk;

  multi_channel_double_tap_detector_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_tap_mask       (in_tap_mask),
    .in_time_ms        (in_time_ms),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_packed_counts (out_packed_counts),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  mcdt_tap_count_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_tap_mask       (in_tap_mask),
    .in_time_ms        (in_time_ms),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_packed_counts (out_packed_counts),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .fail_count        (fail_count),
    .pending           (pending),
    .reports_seen      (reports_seen)
  );

  // Watchdog: give up when no beat moves on any channel for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("watchdog: no beat accepted for %0d cycles", IDLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // Report receiver: mixed stall patterns, with one long hold-off once traffic is random.
  initial begin : report_receiver
    int unsigned span;
    int unsigned mode;
    bit          held;
    held = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && traffic_on) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (RX_HOLD) @(posedge clk);
      end
      mode = $urandom_range(0, 2);
      span = $urandom_range(5, 40);
      repeat (span) begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 1) == 1);
        endcase
        @(posedge clk);
      end
    end
  end

  // Offer one tap beat and hold it until the block takes it; valid stays high.
  task automatic send_tap(input logic [MASK_W-1:0] mask, input logic [TIME_W-1:0] stamp);
    in_valid    <= 1'b1;
    in_tap_mask <= mask;
    in_time_ms  <= stamp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  // One register write; the caller lowers cfg_valid after its last write.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [WIN_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_TAP_WINDOW) tw_ms = value;
    else if (idx == REG_DOUBLE_WINDOW) dw_ms = value;
    reg_writes++;
  endtask

  // Stop offering taps, wait for every owed report, then let the pipeline empty.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned burst_left;
    int unsigned sel;
    int unsigned base;
    logic [TIME_W-1:0] now_ms;
    logic [TIME_W-1:0] step;
    logic [MASK_W-1:0] mask;
    logic [WIN_W-1:0]  next_tw;
    logic [WIN_W-1:0]  next_dw;
    burst_left = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Tap window closes exactly at its length after two single taps.
    send_tap(16'h0000, 32'd5);
    send_tap(16'h0001, 32'd100);
    send_tap(16'h8000, 32'd399);
    send_tap(16'h0000, 32'd400);
    send_tap(16'hFFFF, 32'd0);
    // Double-tap across the time wrap, then promotion of single taps at its end.
    send_tap(16'h00FF, 32'hFFFF_FF00);
    send_tap(16'h0003, 32'h0000_0010);
    send_tap(16'h0F00, 32'h0000_0010 + 32'd199);
    send_tap(16'hFFFF, 32'h0000_0010 + 32'd200);
    send_tap(16'h0000, 32'h0000_0000);

    // Zero-length windows: the tap window expires on the very next beat.
    settle();
    cfg_write(REG_TAP_WINDOW, 16'd0);
    cfg_write(REG_DOUBLE_WINDOW, 16'd0);
    cfg_valid <= 1'b0;
    send_tap(16'h1234, 32'd1000);
    send_tap(16'hFFFF, 32'd1000);
    send_tap(16'hEDCB, 32'hFFFF_FFFF);

    // Longest tap window, zero double window; writes past the register file change nothing.
    settle();
    cfg_write(REG_TAP_WINDOW, 16'hFFFF);
    cfg_write(REG_SPARE_LO, 16'hFFFF);
    cfg_write(REG_SPARE_HI, 16'h5A5A);
    cfg_valid <= 1'b0;
    send_tap(16'h0001, 32'd0);
    send_tap(16'h0001, 32'd65534);
    send_tap(16'hFFFF, 32'd65534);
    send_tap(16'h0000, 32'd70000);

    // Random traffic under a series of window settings, extremes included.
    now_ms = $urandom;
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0: begin next_tw = 16'd300;   next_dw = 16'd200;   end
        1: begin next_tw = 16'hFFFF;  next_dw = 16'hFFFF;  end
        2: begin next_tw = 16'd0;     next_dw = 16'hFFFF;  end
        3: begin next_tw = 16'hFFFF;  next_dw = 16'd0;     end
        4: begin next_tw = WIN_W'($urandom);  next_dw = WIN_W'($urandom);  end
        5: begin next_tw = 16'd7;     next_dw = 16'd3;     end
        default: begin
          next_tw = WIN_W'($urandom_range(1, 1000));
          next_dw = WIN_W'($urandom_range(1, 1000));
        end
      endcase
      if (ph == 4) cfg_write(REG_SPARE_LO, WIN_W'($urandom));
      cfg_write(REG_TAP_WINDOW, next_tw);
      cfg_write(REG_DOUBLE_WINDOW, next_dw);
      cfg_valid <= 1'b0;
      traffic_on = 1'b1;

      repeat (PHASE_BEATS) begin
        // Sender bursts with random gaps; some bursts run long with no gap at all.
        if (burst_left == 0) begin
          sel = $urandom_range(0, 6);
          if (sel != 0) begin
            in_valid <= 1'b0;
            repeat (sel) @(posedge clk);
          end
          burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 24);
        end
        burst_left--;

        // Time steps are mostly short against the windows so sequences run their course.
        base = ($urandom_range(0, 1) != 0) ? 32'(tw_ms) : 32'(dw_ms);
        sel  = $urandom_range(0, 99);
        if (sel < 65)      step = $urandom_range(0, base / 2 + 1);
        else if (sel < 80) step = base + $urandom_range(0, 2) - 1;
        else if (sel < 92) step = $urandom;
        else               step = '0;
        now_ms = now_ms + step;

        // Mostly sparse taps so channels reach two at different times.
        sel = $urandom_range(0, 99);
        if (sel < 45)      mask = 16'h0001 << $urandom_range(0, 15);
        else if (sel < 60) mask = (16'h0001 << $urandom_range(0, 15)) |
                                  (16'h0001 << $urandom_range(0, 15));
        else if (sel < 75) mask = '0;
        else if (sel < 95) mask = MASK_W'($urandom);
        else               mask = '1;
        send_tap(mask, now_ms);
      end
    end

    settle();
    if (pending != 0) $display("%0d count reports never arrived", pending);
    $display("Summary: %0d tap beats and %0d register writes driven, %0d count reports checked.",
             beats_sent, reg_writes, reports_seen);
    $display("Summary: windows swept from 0 to 65535 ms with a %0d-cycle receiver hold-off.",
             RX_HOLD);
    if (fail_count == 0 && pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
